[src/ixg_pkg.sv]
// Shared constants, configuration and item types for the image gradient stream.
package ixg_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_CHANNELS = 4;
	localparam int SAMPLE_BITS  = 16;
	localparam int MAX_HEIGHT   = 2048;

	// Port widths of the result fields
	localparam int GRAD_W = 18;
	localparam int COL_W  = 11;
	localparam int ROW_W  = 11;
	localparam int CHAN_W = 2;

	// Configuration register widths
	localparam int CFG_DIM_W  = 12;
	localparam int CFG_CHAN_W = 3;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	// Internal counter widths
	localparam int COL_BITS  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WCNT_BITS = $clog2(MAX_WIDTH) + 1;
	localparam int HCNT_BITS = $clog2(MAX_HEIGHT) + 1;
	localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
	localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NC_BITS   = $clog2(MAX_CHANNELS) + 1;
	localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_CHANNELS);
	localparam int DIFF_BITS = SAMPLE_BITS + 2;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CHANS  = 2'd2;

	localparam logic [CFG_DIM_W-1:0]  WIDTH_RESET  = CFG_DIM_W'(640);
	localparam logic [CFG_DIM_W-1:0]  HEIGHT_RESET = CFG_DIM_W'(480);
	localparam logic [CFG_CHAN_W-1:0] CHANS_RESET  = CFG_CHAN_W'(3);

	// Clamped frame geometry in use
	typedef struct packed {
		logic [WCNT_BITS-1:0] width;
		logic [HCNT_BITS-1:0] height;
		logic [NC_BITS-1:0]   chans;
	} ixg_cfg_t;

	// Position and border flags of one item
	typedef struct packed {
		logic                produce;
		logic                flush;
		logic                first_row;
		logic                col_first;
		logic                col_last;
		logic                sel;
		logic                frame_end;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic [CH_BITS-1:0]  chan;
	} ixg_item_t;

endpackage

[src/ixg_row_store.sv]
// Row store: one write port, two registered read ports.
module ixg_row_store #(
	parameter int ADDR_BITS = 13,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr0,
	input  logic [ADDR_BITS-1:0] rd_addr1,
	output logic [DATA_BITS-1:0] rd_data0,
	output logic [DATA_BITS-1:0] rd_data1
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

[src/ixg_ctrl.sv]
// Raster position counters, store addressing and border flags.
module ixg_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         accept,
	input  ixg_pkg::ixg_cfg_t            cfg,
	output ixg_pkg::ixg_item_t           item,
	output logic [ixg_pkg::ADDR_BITS-1:0] rd_addr0,
	output logic [ixg_pkg::ADDR_BITS-1:0] rd_addr1,
	output logic                         wr_en,
	output logic                         wr_sel
);
	import ixg_pkg::*;

	logic [COL_BITS-1:0]  col_q;
	logic [CH_BITS-1:0]   ch_q;
	logic [HCNT_BITS-1:0] row_q;
	logic                 sel_q;
	logic [ADDR_BITS-1:0] base_q;

	logic                 last_ch;
	logic                 last_col;
	logic                 flush;
	logic [ADDR_BITS-1:0] idx;
	logic [HCNT_BITS-1:0] row_m1;

	assign last_ch  = (NC_BITS'(ch_q) + NC_BITS'(1)) >= cfg.chans;
	assign last_col = (WCNT_BITS'(col_q) + WCNT_BITS'(1)) >= cfg.width;
	assign flush    = row_q >= cfg.height;
	assign idx      = base_q + ADDR_BITS'(ch_q);
	assign row_m1   = row_q - HCNT_BITS'(1);

	assign rd_addr0 = idx;
	assign rd_addr1 = last_col ? idx : idx + ADDR_BITS'(cfg.chans);
	assign wr_en    = accept && !flush;
	assign wr_sel   = sel_q;

	always_comb begin
		item.produce   = row_q != '0;
		item.flush     = flush;
		item.first_row = row_q == HCNT_BITS'(1);
		item.col_first = col_q == '0;
		item.col_last  = last_col;
		item.sel       = sel_q;
		item.frame_end = flush && last_col && last_ch;
		item.col       = col_q;
		item.row       = row_m1[ROW_BITS-1:0];
		item.chan      = ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			ch_q   <= '0;
			row_q  <= '0;
			sel_q  <= 1'b0;
			base_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			ch_q   <= '0;
			row_q  <= '0;
			sel_q  <= 1'b0;
			base_q <= '0;
		end else if (accept) begin
			if (!last_ch) begin
				ch_q <= ch_q + CH_BITS'(1);
			end else begin
				ch_q <= '0;
				if (!last_col) begin
					col_q  <= col_q + COL_BITS'(1);
					base_q <= base_q + ADDR_BITS'(cfg.chans);
				end else begin
					col_q  <= '0;
					base_q <= '0;
					// flush row done: back to the start of a frame
					if (row_q >= cfg.height) begin
						row_q <= '0;
						sel_q <= 1'b0;
					end else begin
						row_q <= row_q + HCNT_BITS'(1);
						sel_q <= !sel_q;
					end
				end
			end
		end
	end

endmodule

[src/ixg_grad.sv]
// Gradient arithmetic and result register.
module ixg_grad (
	input  logic                                clk,
	input  logic                                load,
	input  ixg_pkg::ixg_item_t                  item_s1,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] sample_s1,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] a_cur,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] a_right,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] b_cur,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] b_right,
	output logic signed [ixg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [ixg_pkg::GRAD_W-1:0]   grad_y,
	output logic [ixg_pkg::COL_W-1:0]           col,
	output logic [ixg_pkg::ROW_W-1:0]           row,
	output logic [ixg_pkg::CHAN_W-1:0]          channel,
	output logic                                frame_end
);
	import ixg_pkg::*;

	// previous-row sample one pixel back, per channel
	logic signed [SAMPLE_BITS-1:0] left_q [MAX_CHANNELS];

	logic signed [SAMPLE_BITS-1:0] cur;
	logic signed [SAMPLE_BITS-1:0] right;
	logic signed [SAMPLE_BITS-1:0] older;
	logic signed [SAMPLE_BITS-1:0] left;
	logic signed [DIFF_BITS-1:0]   gx;
	logic signed [DIFF_BITS-1:0]   gy;

	// the store taking the incoming row holds the row before the previous one
	assign cur   = item_s1.sel ? a_cur : b_cur;
	assign right = item_s1.sel ? a_right : b_right;
	assign older = item_s1.sel ? b_cur : a_cur;
	assign left  = left_q[item_s1.chan];

	always_comb begin
		if (item_s1.col_first) begin
			gx = (DIFF_BITS'(right) - DIFF_BITS'(cur)) <<< 1;
		end else if (item_s1.col_last) begin
			gx = (DIFF_BITS'(cur) - DIFF_BITS'(left)) <<< 1;
		end else begin
			gx = DIFF_BITS'(right) - DIFF_BITS'(left);
		end

		if (item_s1.first_row) begin
			gy = (DIFF_BITS'(sample_s1) - DIFF_BITS'(cur)) <<< 1;
		end else if (item_s1.flush) begin
			gy = (DIFF_BITS'(cur) - DIFF_BITS'(older)) <<< 1;
		end else begin
			gy = DIFF_BITS'(sample_s1) - DIFF_BITS'(older);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q[item_s1.chan] <= cur;
			grad_x    <= GRAD_W'(gx);
			grad_y    <= GRAD_W'(gy);
			col       <= COL_W'(item_s1.col);
			row       <= ROW_W'(item_s1.row);
			channel   <= CHAN_W'(item_s1.chan);
			frame_end <= item_s1.frame_end;
		end
	end

endmodule

[src/image_xy_gradient_stream_top.sv]
// Top level: register port, item pipeline and row stores of the image gradient stream.
// An item is registered in item_s1, its result in ixg_grad; results trail the input
// by one row (gradient of row r while row r+1 arrives).
// Throughput: one item per cycle unless grad_stall holds the output, set by one read
// of each row store port per cycle. Reset: counters cleared, registers to 640 x 480
// with 3 channels; row stores are not cleared and need no clearing pass.
module image_xy_gradient_stream_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ixg_pkg::PADDR_W-1:0]         paddr,
	input  logic [ixg_pkg::PDATA_W-1:0]         pwdata,
	output logic [ixg_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [ixg_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                grad_valid,
	input  logic                                grad_stall,
	output logic signed [ixg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [ixg_pkg::GRAD_W-1:0]   grad_y,
	output logic [ixg_pkg::COL_W-1:0]           col,
	output logic [ixg_pkg::ROW_W-1:0]           row,
	output logic [ixg_pkg::CHAN_W-1:0]          channel,
	output logic                                frame_end
);
	import ixg_pkg::*;

	logic [CFG_DIM_W-1:0]  width_q;
	logic [CFG_DIM_W-1:0]  height_q;
	logic [CFG_CHAN_W-1:0] chans_q;
	ixg_cfg_t              cfg;

	logic                  cfg_wr;
	logic                  restart;
	logic                  accept;
	logic                  advance;
	logic                  s1_load;

	ixg_item_t             item;
	ixg_item_t             item_s1;
	logic                  valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;

	logic [ADDR_BITS-1:0]  rd_addr0;
	logic [ADDR_BITS-1:0]  rd_addr1;
	logic                  wr_en;
	logic                  wr_sel;
	logic [SAMPLE_BITS-1:0] a_cur;
	logic [SAMPLE_BITS-1:0] a_right;
	logic [SAMPLE_BITS-1:0] b_cur;
	logic [SAMPLE_BITS-1:0] b_right;

	// ---- register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
		paddr[3:2] == REG_CHANS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			chans_q  <= CHANS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
				REG_CHANS:  chans_q  <= pwdata[CFG_CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_CHANS:  prdata = PDATA_W'(chans_q);
			default:    prdata = '0;
		endcase
	end

	// clamp to the supported range
	always_comb begin
		if (width_q < CFG_DIM_W'(2))
			cfg.width = WCNT_BITS'(2);
		else if (32'(width_q) > MAX_WIDTH)
			cfg.width = WCNT_BITS'(MAX_WIDTH);
		else
			cfg.width = WCNT_BITS'(width_q);

		if (height_q < CFG_DIM_W'(2))
			cfg.height = HCNT_BITS'(2);
		else if (32'(height_q) > MAX_HEIGHT)
			cfg.height = HCNT_BITS'(MAX_HEIGHT);
		else
			cfg.height = HCNT_BITS'(height_q);

		if (chans_q < CFG_CHAN_W'(1))
			cfg.chans = NC_BITS'(1);
		else if (32'(chans_q) > MAX_CHANNELS)
			cfg.chans = NC_BITS'(MAX_CHANNELS);
		else
			cfg.chans = NC_BITS'(chans_q);
	end

	// ---- handshake
	assign advance      = !grad_valid || !grad_stall;
	assign s1_load      = !valid_s1 || advance;
	assign sample_stall = !s1_load;
	assign accept       = sample_valid && s1_load;

	ixg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.accept   (accept),
		.cfg      (cfg),
		.item     (item),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.wr_en    (wr_en),
		.wr_sel   (wr_sel)
	);

	ixg_row_store #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(SAMPLE_BITS)) u_store_a (
		.clk      (clk),
		.wr_en    (wr_en && !wr_sel),
		.wr_addr  (rd_addr0),
		.wr_data  (sample),
		.rd_en    (s1_load),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (a_cur),
		.rd_data1 (a_right)
	);

	ixg_row_store #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(SAMPLE_BITS)) u_store_b (
		.clk      (clk),
		.wr_en    (wr_en && wr_sel),
		.wr_addr  (rd_addr0),
		.wr_data  (sample),
		.rd_en    (s1_load),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (b_cur),
		.rd_data1 (b_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			grad_valid <= 1'b0;
		end else begin
			if (s1_load)
				valid_s1 <= sample_valid;
			if (advance)
				grad_valid <= valid_s1 && item_s1.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			item_s1   <= item;
			sample_s1 <= sample;
		end
	end

	ixg_grad u_grad (
		.clk       (clk),
		.load      (advance && valid_s1),
		.item_s1   (item_s1),
		.sample_s1 (sample_s1),
		.a_cur     (a_cur),
		.a_right   (a_right),
		.b_cur     (b_cur),
		.b_right   (b_right),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.col       (col),
		.row       (row),
		.channel   (channel),
		.frame_end (frame_end)
	);

	// ---- checks
	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && frame_end |->
			(WCNT_BITS'(col) + WCNT_BITS'(1) == cfg.width) &&
			(NC_BITS'(channel) + NC_BITS'(1) == cfg.chans))
		else $error("frame_end off the last pixel and channel");

	a_result_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && item_s1.produce |=> grad_valid)
		else $error("producing item lost between stages");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid |-> (HCNT_BITS'(row) < cfg.height))
		else $error("result row beyond frame height");

endmodule
